[rtl/bvls_pkg.sv]
package bvls_pkg;

  // Width of the vector fields on the ports.
  localparam int unsigned VEC_BITS = 64;
  localparam int unsigned LEN_W = 7;

  typedef logic [VEC_BITS-1:0] vec_t;
  typedef logic [LEN_W-1:0] len_t;

  // Command codes.
  typedef enum logic [3:0] {
    CMD_XOR    = 4'd0,
    CMD_OR     = 4'd1,
    CMD_AND    = 4'd2,
    CMD_INVERT = 4'd3,
    CMD_SHL    = 4'd4,
    CMD_SHR    = 4'd5,
    CMD_ROTL   = 4'd6,
    CMD_ROTR   = 4'd7,
    CMD_REV    = 4'd8,
    CMD_LOAD   = 4'd9
  } cmd_t;

  // Input beat.
  typedef struct packed {
    logic [3:0] cmd;
    vec_t       a_value;
    len_t       a_len;
    vec_t       b_value;
    len_t       b_len;
    len_t       shift_dist;
    len_t       range_start;
    len_t       range_end;
  } in_t;

  // Result beat.
  typedef struct packed {
    vec_t result_value;
    len_t result_len;
    logic status;
  } out_t;

  // Execute-stage operands, produced by the decode stage.
  typedef struct packed {
    logic [3:0] op;
    vec_t       a;
    len_t       amt;
    logic       rev_left;
    vec_t       rmask;
    vec_t       pre_val;
    len_t       len;
    logic       clear;
    logic       bad;
  } exec_t;

  // Mask with the low len bits set; len of 64 or more gives all ones.
  function automatic vec_t len_mask(input len_t len);
    vec_t m;
    if (len >= len_t'(VEC_BITS)) begin
      m = '1;
    end else begin
      m = (vec_t'(1) << len) - vec_t'(1);
    end
    return m;
  endfunction

endpackage

[rtl/bvls_exec.sv]
module bvls_exec (
  input  bvls_pkg::exec_t ex,
  output bvls_pkg::out_t  res
);
  import bvls_pkg::*;

  vec_t rev;
  vec_t rev_sh;
  vec_t val;

  // Full-width bit reversal feeding the range mirror.
  always_comb begin
    for (int i = 0; i < VEC_BITS; i++) begin
      rev[i] = ex.a[VEC_BITS-1-i];
    end
    rev_sh = ex.rev_left ? (rev << ex.amt) : (rev >> ex.amt);
  end

  // Barrel shifts, rotation and range reversal; logic and load results pass through.
  always_comb begin
    val = '0;
    case (ex.op)
      CMD_XOR, CMD_OR, CMD_AND, CMD_INVERT, CMD_LOAD: begin
        val = ex.pre_val;
      end
      CMD_SHL: begin
        val = ex.clear ? '0 : ((ex.a << ex.amt) & len_mask(ex.len));
      end
      CMD_SHR: begin
        val = ex.clear ? '0 : (ex.a >> ex.amt);
      end
      CMD_ROTL, CMD_ROTR: begin
        if (ex.amt == '0) begin
          val = ex.a;
        end else begin
          val = ((ex.a << ex.amt) | (ex.a >> (ex.len - ex.amt))) & len_mask(ex.len);
        end
      end
      CMD_REV: begin
        val = (ex.a & ~ex.rmask) | (rev_sh & ex.rmask);
      end
      default: begin
        val = '0;
      end
    endcase
    if (ex.bad) begin
      val = '0;
    end
    res.result_value = val;
    res.result_len   = ex.len;
    res.status       = ex.bad;
  end

endmodule

[rtl/bit_vector_logic_shift_unit_top.sv]
// Bit vector logic, shift, rotate, reverse and load unit.
// Input channel in_valid/in_ready/in_data carries one command per beat: an
// operation code, two vectors with explicit lengths, a shift distance and a
// bit range. Output channel out_valid/out_ready/out_data returns exactly one
// result beat per command, in order: the result vector, its length and a
// bad-argument status bit.
// An accepted beat passes through the stage 1 register, the stage 2 register
// and the output register, where it waits until out_ready takes it.
// Throughput is one beat per cycle: the three stages
// (operand masking with the upper remainder steps, decode with the lower
// remainder steps and leading-one search, then the barrel shifter) each take
// a new beat whenever the stage after them moves or is empty.
// When the receiver holds out_ready low the result stays on out_data and the
// stages behind it fill up; in_ready drops only once every stage is full.
// Reset empties all stages; no state survives between commands.
module bit_vector_logic_shift_unit_top #(
  parameter int unsigned VECTOR_BYTES = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bvls_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bvls_pkg::out_t  out_data
);
  import bvls_pkg::*;

  localparam len_t W_LEN = len_t'(VECTOR_BYTES * 8);

  typedef struct packed {
    logic [3:0] cmd;
    vec_t       a;
    vec_t       b;
    vec_t       ld;
    len_t       alen;
    len_t       blen;
    len_t       sh;
    len_t       rs;
    len_t       re;
    len_t       rem;
  } s1_t;

  logic  v1_r, v2_r, v3_r;
  logic  en1, en2, en3;
  s1_t   s1_r, s1_nxt;
  exec_t s2_r, s2_nxt;
  out_t  out_r, res_nxt;

  // Stage enables: a stage loads when it is empty or its successor moves.
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1: clamp lengths, mask operands, upper remainder steps.
  always_comb begin
    logic [12:0] r;
    logic [12:0] d;
    s1_nxt.cmd  = in_data.cmd;
    s1_nxt.alen = (in_data.a_len > W_LEN) ? W_LEN : in_data.a_len;
    s1_nxt.blen = (in_data.b_len > W_LEN) ? W_LEN : in_data.b_len;
    s1_nxt.a    = in_data.a_value & len_mask(s1_nxt.alen);
    s1_nxt.b    = in_data.b_value & len_mask(s1_nxt.blen);
    s1_nxt.ld   = in_data.a_value & len_mask(W_LEN);
    s1_nxt.sh   = in_data.shift_dist;
    s1_nxt.rs   = in_data.range_start;
    s1_nxt.re   = in_data.range_end;
    r = {6'd0, in_data.shift_dist};
    for (int j = 6; j >= 3; j--) begin
      d = {6'd0, s1_nxt.alen} << j;
      if (r >= d) begin
        r = r - d;
      end
    end
    s1_nxt.rem = r[6:0];
  end

  // Stage 2: finish the remainder, logic ops, lengths and shifter controls.
  always_comb begin
    logic [12:0] r;
    logic [12:0] d;
    len_t        k;
    len_t        longer;
    len_t        shorter;
    len_t        lead;
    logic [7:0]  rsum;
    logic [7:0]  lsum;
    vec_t        ms;
    r = {6'd0, s1_r.rem};
    for (int j = 2; j >= 0; j--) begin
      d = {6'd0, s1_r.alen} << j;
      if (r >= d) begin
        r = r - d;
      end
    end
    k = r[6:0];
    if (s1_r.cmd == CMD_ROTR && k != '0) begin
      k = s1_r.alen - k;
    end
    longer  = (s1_r.alen > s1_r.blen) ? s1_r.alen : s1_r.blen;
    shorter = (s1_r.alen > s1_r.blen) ? s1_r.blen : s1_r.alen;
    ms      = len_mask(shorter);
    // Highest set bit of the load value.
    lead = '0;
    for (int i = 0; i < VEC_BITS; i++) begin
      if (s1_r.ld[i]) begin
        lead = len_t'(i + 1);
      end
    end
    rsum = {1'b0, s1_r.rs} + {1'b0, s1_r.re};
    lsum = {1'b0, s1_r.alen} + {1'b0, s1_r.sh};

    s2_nxt.op       = s1_r.cmd;
    s2_nxt.a        = s1_r.a;
    s2_nxt.amt      = s1_r.sh;
    s2_nxt.rev_left = 1'b0;
    s2_nxt.rmask    = len_mask(s1_r.re) & ~len_mask(s1_r.rs);
    s2_nxt.pre_val  = '0;
    s2_nxt.len      = '0;
    s2_nxt.clear    = 1'b0;
    s2_nxt.bad      = 1'b0;
    case (s1_r.cmd)
      CMD_XOR: begin
        s2_nxt.pre_val = s1_r.a ^ s1_r.b;
        s2_nxt.len     = longer;
      end
      CMD_OR: begin
        s2_nxt.pre_val = s1_r.a | s1_r.b;
        s2_nxt.len     = longer;
      end
      CMD_AND: begin
        s2_nxt.pre_val = (s1_r.a & s1_r.b & ms) | ((s1_r.a | s1_r.b) & ~ms);
        s2_nxt.len     = longer;
      end
      CMD_INVERT: begin
        s2_nxt.pre_val = ~s1_r.a & len_mask(s1_r.alen);
        s2_nxt.len     = s1_r.alen;
      end
      CMD_SHL: begin
        s2_nxt.clear = (s1_r.sh >= W_LEN);
        if (s2_nxt.clear) begin
          s2_nxt.len = len_t'(1);
        end else begin
          s2_nxt.len = (lsum > {1'b0, W_LEN}) ? W_LEN : lsum[6:0];
        end
      end
      CMD_SHR: begin
        s2_nxt.clear = (s1_r.sh >= s1_r.alen);
        s2_nxt.len   = s2_nxt.clear ? len_t'(1) : (s1_r.alen - s1_r.sh);
      end
      CMD_ROTL, CMD_ROTR: begin
        s2_nxt.amt = k;
        s2_nxt.len = s1_r.alen;
        s2_nxt.bad = (s1_r.alen == '0);
      end
      CMD_REV: begin
        // Mirrored bit i comes from bit rs+re-1-i of a.
        s2_nxt.rev_left = (rsum > 8'(VEC_BITS));
        if (s2_nxt.rev_left) begin
          s2_nxt.amt = len_t'(rsum - 8'(VEC_BITS));
        end else begin
          s2_nxt.amt = len_t'(8'(VEC_BITS) - rsum);
        end
        s2_nxt.len = (s1_r.alen > s1_r.re) ? s1_r.alen : s1_r.re;
        s2_nxt.bad = (s1_r.rs > s1_r.re) || (s1_r.re > W_LEN);
      end
      CMD_LOAD: begin
        s2_nxt.pre_val = s1_r.ld;
        s2_nxt.len     = lead;
      end
      default: begin
        s2_nxt.bad = 1'b1;
      end
    endcase
    if (s2_nxt.bad) begin
      s2_nxt.len = '0;
    end
  end

  // Stage 3: shifter and result assembly.
  bvls_exec u_exec (
    .ex  (s2_r),
    .res (res_nxt)
  );

  // Valid bits travel with the beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Payload registers load only with a live beat.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (en2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (en3 && v2_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

[dv/bvls_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the bit vector unit, predicts each result from
// the accepted command beat and compares it with the result beats in order.
module bvls_checker #(
  parameter int unsigned VECTOR_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  bvls_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  bvls_pkg::out_t out_data,
  output int             mismatches,
  output int             outstanding,
  output int             results_seen,
  output int             bad_args_seen
);
  import bvls_pkg::*;

  localparam int unsigned WIDTH = VECTOR_BYTES * 8;

  // One predicted result together with the command that caused it.
  typedef struct packed {
    in_t  cause;
    out_t result;
  } expected_beat_t;

  expected_beat_t expected_results[$];

  // Low n bits set; 64 or more gives all ones.
  function automatic vec_t low_ones(input int unsigned n);
    if (n >= VEC_BITS) begin
      return '1;
    end
    return (vec_t'(1) << n) - vec_t'(1);
  endfunction

  function automatic int unsigned clip_len(input int unsigned n);
    return (n > WIDTH) ? WIDTH : n;
  endfunction

  // Computes the result of one command beat.
  function automatic out_t predict_vector_op(input in_t item);
    out_t        res;
    int unsigned alen, blen, sh, rs, re, longer, shorter, k, len;
    vec_t        a, b, v;
    logic        bad;
    alen = clip_len(32'(item.a_len));
    blen = clip_len(32'(item.b_len));
    a = item.a_value & low_ones(alen);
    b = item.b_value & low_ones(blen);
    sh = 32'(item.shift_dist);
    rs = 32'(item.range_start);
    re = 32'(item.range_end);
    longer = (alen > blen) ? alen : blen;
    shorter = (alen > blen) ? blen : alen;
    v = '0;
    len = 0;
    bad = 1'b0;
    case (item.cmd)
      CMD_XOR: begin
        v = a ^ b;
        len = longer;
      end
      CMD_OR: begin
        v = a | b;
        len = longer;
      end
      CMD_AND: begin
        // Above the shorter operand the longer one passes through.
        v = (a & b & low_ones(shorter)) | ((a | b) & ~low_ones(shorter));
        len = longer;
      end
      CMD_INVERT: begin
        v = ~a & low_ones(alen);
        len = alen;
      end
      CMD_SHL: begin
        if (sh >= WIDTH) begin
          v = '0;
          len = 1;
        end else begin
          len = clip_len(alen + sh);
          v = (a << sh) & low_ones(len);
        end
      end
      CMD_SHR: begin
        if (sh >= alen) begin
          v = '0;
          len = 1;
        end else begin
          len = alen - sh;
          v = a >> sh;
        end
      end
      CMD_ROTL, CMD_ROTR: begin
        if (alen == 0) begin
          bad = 1'b1;
        end else begin
          // A right rotation is a left rotation by the complement.
          k = sh % alen;
          if (item.cmd == CMD_ROTR && k != 0) begin
            k = alen - k;
          end
          if (k == 0) begin
            v = a;
          end else begin
            v = ((a << k) | (a >> (alen - k))) & low_ones(alen);
          end
          len = alen;
        end
      end
      CMD_REV: begin
        if (rs > re || re > WIDTH) begin
          bad = 1'b1;
        end else begin
          v = a;
          for (int unsigned i = rs; i < re; i++) begin
            v[i] = a[re - 1 - (i - rs)];
          end
          len = (alen > re) ? alen : re;
          v = v & low_ones(len);
        end
      end
      CMD_LOAD: begin
        // Length runs up to the highest set bit.
        v = item.a_value & low_ones(WIDTH);
        for (int unsigned j = 0; j < WIDTH; j++) begin
          if (v[j]) begin
            len = j + 1;
          end
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (bad) begin
      v = '0;
      len = 0;
    end
    res.result_value = v;
    res.result_len = len_t'(len);
    res.status = bad;
    return res;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input vec_t got, input vec_t want,
                                 input in_t cause);
    $display("MISMATCH %s at %0t ns: got %h, expected %h (cmd %0d)",
             what, $time, got, want, cause.cmd);
    mismatches++;
  endtask

  // Compare result beats against the oldest prediction, then queue new ones.
  always @(posedge clk) begin : watch
    expected_beat_t oldest;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.status) begin
          bad_args_seen++;
        end
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.result_value, '0, '0);
        end else begin
          oldest = expected_results.pop_front();
          if (out_data.result_value !== oldest.result.result_value) begin
            report_mismatch("result_value", out_data.result_value,
                            oldest.result.result_value, oldest.cause);
          end
          if (out_data.result_len !== oldest.result.result_len) begin
            report_mismatch("result_len", vec_t'(out_data.result_len),
                            vec_t'(oldest.result.result_len), oldest.cause);
          end
          if (out_data.status !== oldest.result.status) begin
            report_mismatch("status", vec_t'(out_data.status),
                            vec_t'(oldest.result.status), oldest.cause);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back('{cause: in_data, result: predict_vector_op(in_data)});
      end
      outstanding = expected_results.size();
    end else begin
      // Counters start from zero while the block is held in reset.
      mismatches = 0;
      outstanding = 0;
      results_seen = 0;
      bad_args_seen = 0;
    end
  end

endmodule

[dv/bit_vector_logic_shift_unit_top_tb.sv]
`timescale 1ns / 1ps

// Drives command beats into the bit vector unit under several idle and
// stall mixes; the checker beside the block predicts and compares.
module bit_vector_logic_shift_unit_top_tb;
  import bvls_pkg::*;

  localparam logic [3:0] FIRST_UNUSED_CMD = 4'd10;
  localparam logic [3:0] LAST_UNUSED_CMD = 4'd15;
  localparam int RANDOM_PER_PHASE = 220;
  localparam int DRAIN_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int bad_args_seen;
  int sent_count;
  int sender_idle_pct;
  int recv_stall_pct;

  bit_vector_logic_shift_unit_top #(
    .VECTOR_BYTES(8)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  bvls_checker #(
    .VECTOR_BYTES(8)
  ) result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .bad_args_seen(bad_args_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver back-pressure, redrawn every cycle; held off during reset.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Lengths are mostly legal, sometimes exactly the width, sometimes beyond it.
  function automatic len_t random_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      return len_t'($urandom_range(64));
    end else if (pick < 88) begin
      return len_t'(64);
    end
    return len_t'($urandom_range(127, 65));
  endfunction

  function automatic vec_t random_vector();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return vec_t'(1) << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_t make_random_command();
    in_t c;
    int  re;
    c = '0;
    if ($urandom_range(99) < 6) begin
      c.cmd = 4'($urandom_range(LAST_UNUSED_CMD, FIRST_UNUSED_CMD));
    end else begin
      c.cmd = 4'($urandom_range(CMD_LOAD, CMD_XOR));
    end
    c.a_value = random_vector();
    c.a_len = random_length();
    c.b_value = random_vector();
    c.b_len = random_length();
    c.shift_dist = ($urandom_range(99) < 70) ? len_t'($urandom_range(70))
                                              : len_t'($urandom_range(127));
    // Mostly well-formed ranges, the rest anywhere in the field.
    if ($urandom_range(99) < 80) begin
      re = $urandom_range(64);
      c.range_end = len_t'(re);
      c.range_start = len_t'($urandom_range(re));
    end else begin
      c.range_end = len_t'($urandom_range(127));
      c.range_start = len_t'($urandom_range(127));
    end
    return c;
  endfunction

  // Presents one beat from a falling edge and returns at the falling edge
  // after it is taken.
  task automatic push_command(input in_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic issue_cmd(input logic [3:0] op, input vec_t a, input int unsigned al,
                           input vec_t b, input int unsigned bl, input int unsigned sh,
                           input int unsigned rs, input int unsigned re);
    in_t c;
    c.cmd = op;
    c.a_value = a;
    c.a_len = len_t'(al);
    c.b_value = b;
    c.b_len = len_t'(bl);
    c.shift_dist = len_t'(sh);
    c.range_start = len_t'(rs);
    c.range_end = len_t'(re);
    push_command(c);
  endtask

  // Holds the sender off until every predicted result has come back or DRAIN_LIMIT is reached.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sent_count = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed edge cases under light mixed idling.
    sender_idle_pct = 15;
    recv_stall_pct = 15;
    issue_cmd(CMD_XOR, '1, 64, 64'h0000_0000_0000_00ff, 8, 0, 0, 0);
    issue_cmd(CMD_OR, 64'hf0f0, 16, 64'h0f, 127, 0, 0, 0);
    issue_cmd(CMD_AND, '1, 64, 64'h5, 3, 0, 0, 0);
    issue_cmd(CMD_AND, 64'h1234_5678, 100, '1, 0, 0, 0, 0);
    issue_cmd(CMD_INVERT, '0, 64, '0, 0, 0, 0, 0);
    issue_cmd(CMD_INVERT, 64'hdead_beef_cafe_f00d, 0, '0, 0, 0, 0, 0);
    issue_cmd(CMD_SHL, '1, 64, '0, 0, 0, 0, 0);
    issue_cmd(CMD_SHL, 64'h1, 1, '0, 0, 63, 0, 0);
    issue_cmd(CMD_SHL, '1, 10, '0, 0, 64, 0, 0);
    issue_cmd(CMD_SHL, 64'habc, 12, '0, 0, 60, 0, 0);
    issue_cmd(CMD_SHL, '1, 127, '1, 127, 127, 127, 127);
    issue_cmd(CMD_SHR, 64'hff00, 16, '0, 0, 8, 0, 0);
    issue_cmd(CMD_SHR, '1, 64, '0, 0, 64, 0, 0);
    issue_cmd(CMD_SHR, '1, 0, '0, 0, 0, 0, 0);
    issue_cmd(CMD_ROTL, '1, 0, '0, 0, 5, 0, 0);
    issue_cmd(CMD_ROTL, 64'h8000_0000_0000_0001, 64, '0, 0, 1, 0, 0);
    issue_cmd(CMD_ROTR, 64'hb, 4, '0, 0, 9, 0, 0);
    issue_cmd(CMD_ROTR, 64'h55, 7, '0, 0, 7, 0, 0);
    issue_cmd(CMD_REV, 64'h1, 8, '0, 0, 0, 0, 8);
    issue_cmd(CMD_REV, 64'h0123_4567_89ab_cdef, 64, '0, 0, 0, 0, 64);
    issue_cmd(CMD_REV, '1, 64, '0, 0, 0, 5, 3);
    issue_cmd(CMD_REV, '1, 64, '0, 0, 0, 0, 65);
    issue_cmd(CMD_REV, 64'hf, 4, '0, 0, 0, 10, 20);
    issue_cmd(CMD_LOAD, '0, 64, '0, 0, 0, 0, 0);
    issue_cmd(CMD_LOAD, '1, 0, '0, 0, 0, 0, 0);
    issue_cmd(LAST_UNUSED_CMD, '1, 64, '1, 64, 3, 0, 4);
    drain_results();

    // Random commands: no idling, sender idle, receiver stalling, then both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin sender_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        push_command(make_random_command());
      end
      drain_results();
    end

    // Let any stray beat surface before the verdict.
    repeat (10) @(negedge clk);
    $display("Sent %0d commands: directed edge cases, then random ones", sent_count);
    $display("under four idle/stall mixes; %0d results compared, %0d bad-argument.",
             results_seen, bad_args_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bvls_pkg.sv
rtl/bvls_exec.sv
rtl/bit_vector_logic_shift_unit_top.sv
dv/bvls_checker.sv
dv/bit_vector_logic_shift_unit_top_tb.sv
